// ===== rtl/log5_pkg.sv =====
// Shared types, constants and the kernel arithmetic of the 5x5 LoG edge filter.
package log5_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int CFG_W         = 12;
  localparam int ROW_W         = 12;
  localparam int ROW_LIMIT     = 4095;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;
  localparam int LINES         = 4;
  localparam int WIN           = 5;
  localparam int BORDER        = 2;
  localparam int CENTRE_WEIGHT = 16;
  localparam int PIX_MAX       = 255;
  localparam int KSUM_W        = 14;

  typedef logic [7:0] pixel_t;
  typedef pixel_t [LINES-1:0] column_t;
  typedef pixel_t [WIN-1:0][WIN-1:0] window_t;

  typedef struct packed {
    pixel_t pixel;
    logic   drain;
  } in_item_t;

  typedef struct packed {
    pixel_t out_pixel;
    logic   out_last;
  } out_item_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic inner;
  } tag_t;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_MUL,
    ST_POS,
    ST_DIV,
    ST_RUN
  } ctrl_state_t;

  // Weighted neighbourhood sum, clamped to the pixel range.
  function automatic pixel_t kernel(input window_t win);
    logic [9:0]               near_sum;
    logic [10:0]              far_sum;
    logic signed [KSUM_W-1:0] g;
    pixel_t                   res;
    near_sum = 10'(win[2][1]) + 10'(win[2][3]) + 10'(win[1][2]) + 10'(win[3][2]);
    far_sum  = 11'(win[2][0]) + 11'(win[2][4]) + 11'(win[0][2]) + 11'(win[4][2])
             + 11'(win[1][1]) + 11'(win[1][3]) + 11'(win[3][1]) + 11'(win[3][3]);
    g = $signed(KSUM_W'({near_sum, 1'b0})) + $signed(KSUM_W'(far_sum))
      - $signed(KSUM_W'(win[2][2]) * KSUM_W'(CENTRE_WEIGHT));
    if (g[KSUM_W-1]) begin
      res = '0;
    end else if (g > $signed(KSUM_W'(PIX_MAX))) begin
      res = pixel_t'(PIX_MAX);
    end else begin
      res = g[7:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/log5_line_store.sv =====
// Four-line column store with a clearing sweep after reset and write-to-read forwarding.
module log5_line_store #(
  parameter int MAX_WIDTH = log5_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
  input  log5_pkg::column_t             wr_data,
  output log5_pkg::column_t             rd_data,
  output logic                          busy
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  log5_pkg::column_t mem [MAX_WIDTH];
  log5_pkg::column_t rd_q;
  log5_pkg::column_t fwd_q;
  logic              fwd_hit;
  logic              clearing;
  logic [COL_W-1:0]  clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == COL_W'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read that meets a write to the same column takes the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q    <= mem[rd_addr];
      fwd_hit <= wr_en && (wr_addr == rd_addr);
      fwd_q   <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_q : rd_q;
  assign busy    = clearing;

endmodule

// ===== rtl/log5_ctrl.sv =====
// Frame counters, register file and the setup sequencer that re-derives position state.
module log5_ctrl #(
  parameter int MAX_WIDTH = log5_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  log5_pkg::reg_index_t               cfg_index,
  input  logic [log5_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               accept,
  output logic                               busy,
  output logic [$clog2(MAX_WIDTH)-1:0]       col,
  output log5_pkg::tag_t                     tag
);

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WID_W   = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W   = log5_pkg::ROW_W;
  localparam int CNT_W   = ROW_W + COL_W;
  localparam int THR_W   = WID_W + 2;
  localparam int MUL_W   = ROW_W + WID_W;
  localparam int CMP_W   = MUL_W + 1;
  localparam int EXT_W   = (WID_W > log5_pkg::CFG_W) ? WID_W : log5_pkg::CFG_W;
  localparam int STEP_W  = $clog2(CNT_W);
  localparam int RESET_W = (log5_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                               : log5_pkg::WIDTH_RESET;

  log5_pkg::ctrl_state_t state, state_next;

  logic [WID_W-1:0]  width;
  logic [ROW_W-1:0]  height;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [CNT_W-1:0]  emitted_count;
  logic [CNT_W-1:0]  kr;
  logic [WID_W-1:0]  kc;
  logic [CNT_W-1:0]  pos;
  logic [THR_W-1:0]  thr;
  logic [MUL_W-1:0]  total;
  logic [MUL_W-1:0]  prod_row;
  logic [STEP_W-1:0] step;

  logic [EXT_W-1:0]  wval;
  logic [WID_W-1:0]  width_new;
  logic [ROW_W-1:0]  height_new;
  logic              emit, last, inner;
  logic              col_wrap, kc_wrap, row_more;
  logic [CNT_W-1:0]  pos_wrap;
  logic [WID_W:0]    div_cat;
  logic [WID_W+1:0]  div_trial;

  // Clamp register writes to the usable range.
  always_comb begin
    wval = EXT_W'(cfg_data);
    if (wval == '0) begin
      width_new = WID_W'(1);
    end else if (wval > EXT_W'(MAX_WIDTH)) begin
      width_new = WID_W'(MAX_WIDTH);
    end else begin
      width_new = WID_W'(wval);
    end
    height_new = (cfg_data == '0) ? ROW_W'(1) : ROW_W'(cfg_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WID_W'(RESET_W);
      height <= ROW_W'(log5_pkg::HEIGHT_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        log5_pkg::REG_IMAGE_WIDTH:  width  <= width_new;
        log5_pkg::REG_IMAGE_HEIGHT: height <= height_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= log5_pkg::ST_MUL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      log5_pkg::ST_MUL: state_next = log5_pkg::ST_POS;
      log5_pkg::ST_POS: state_next = log5_pkg::ST_DIV;
      log5_pkg::ST_DIV: begin
        if (step == STEP_W'(CNT_W - 1)) begin
          state_next = log5_pkg::ST_RUN;
        end
      end
      log5_pkg::ST_RUN: state_next = log5_pkg::ST_RUN;
      default:          state_next = log5_pkg::ST_MUL;
    endcase
    if (cfg_write) begin
      state_next = log5_pkg::ST_MUL;
    end
  end

  always_comb begin
    emit     = CNT_W'(thr) <= pos;
    last     = emit && ((CMP_W'(emitted_count) + CMP_W'(1)) >= CMP_W'(total));
    inner    = (kr >= CNT_W'(log5_pkg::BORDER))
            && ((CMP_W'(kr) + CMP_W'(log5_pkg::BORDER)) < CMP_W'(height))
            && (kc >= WID_W'(log5_pkg::BORDER))
            && (((WID_W+1)'(kc) + (WID_W+1)'(log5_pkg::BORDER)) < (WID_W+1)'(width));
    col_wrap = ((WID_W+1)'(column_count) + (WID_W+1)'(1)) >= (WID_W+1)'(width);
    kc_wrap  = ((WID_W+1)'(kc) + (WID_W+1)'(1)) >= (WID_W+1)'(width);
    row_more = row_count != ROW_W'(log5_pkg::ROW_LIMIT);
    pos_wrap = pos - CNT_W'(column_count) + (row_more ? CNT_W'(width) : '0);
    div_cat   = {kc, kr[CNT_W-1]};
    div_trial = (WID_W+2)'(div_cat) - (WID_W+2)'(width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      emitted_count <= '0;
      kr            <= '0;
      kc            <= '0;
      pos           <= '0;
      thr           <= '0;
      total         <= '0;
      prod_row      <= '0;
      step          <= '0;
    end else begin
      case (state)
        log5_pkg::ST_MUL: begin
          prod_row <= MUL_W'(row_count) * MUL_W'(width);
          total    <= MUL_W'(width) * MUL_W'(height);
          thr      <= THR_W'({width, 1'b0}) + THR_W'(log5_pkg::BORDER);
          kr       <= emitted_count;
          kc       <= '0;
          step     <= '0;
        end
        log5_pkg::ST_POS: begin
          pos <= CNT_W'(prod_row + MUL_W'(column_count));
        end
        log5_pkg::ST_DIV: begin
          if (!div_trial[WID_W+1]) begin
            kc <= div_trial[WID_W-1:0];
            kr <= {kr[CNT_W-2:0], 1'b1};
          end else begin
            kc <= div_cat[WID_W-1:0];
            kr <= {kr[CNT_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
        end
        log5_pkg::ST_RUN: begin
          if (accept) begin
            if (emit && last) begin
              column_count  <= '0;
              row_count     <= '0;
              emitted_count <= '0;
              kr            <= '0;
              kc            <= '0;
              pos           <= '0;
            end else begin
              if (emit) begin
                emitted_count <= emitted_count + 1'b1;
                if (kc_wrap) begin
                  kc <= '0;
                  kr <= kr + 1'b1;
                end else begin
                  kc <= kc + 1'b1;
                end
              end
              if (col_wrap) begin
                column_count <= '0;
                if (row_more) begin
                  row_count <= row_count + 1'b1;
                end
                pos <= pos_wrap;
              end else begin
                column_count <= column_count + 1'b1;
                pos          <= pos + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign busy      = state != log5_pkg::ST_RUN;
  assign col       = column_count;
  assign tag.emit  = emit;
  assign tag.last  = last;
  assign tag.inner = inner;

endmodule

// ===== rtl/log5_window.sv =====
// 5x5 pixel window, kernel evaluation and the result register.
module log5_window (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  log5_pkg::pixel_t      px,
  input  log5_pkg::tag_t        tag,
  input  log5_pkg::column_t     col_in,
  output log5_pkg::column_t     col_out,
  output logic                  free,
  output logic                  res_valid,
  input  logic                  res_stall,
  output log5_pkg::out_item_t   res
);

  log5_pkg::window_t win, win_next;

  // Shift one column left, new column enters on the right.
  always_comb begin
    for (int r = 0; r < log5_pkg::WIN; r++) begin
      for (int c = 0; c < log5_pkg::WIN - 1; c++) begin
        win_next[r][c] = win[r][c+1];
      end
    end
    for (int r = 0; r < log5_pkg::LINES; r++) begin
      win_next[r][log5_pkg::WIN-1] = col_in[r];
    end
    win_next[log5_pkg::WIN-1][log5_pkg::WIN-1] = px;
    for (int r = 0; r < log5_pkg::LINES - 1; r++) begin
      col_out[r] = col_in[r+1];
    end
    col_out[log5_pkg::LINES-1] = px;
  end

  assign free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (adv) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv && tag.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tag.emit) begin
      res.out_pixel <= tag.inner ? log5_pkg::kernel(win_next)
                                 : win_next[log5_pkg::BORDER][log5_pkg::BORDER];
      res.out_last  <= tag.last;
    end
  end

endmodule

// ===== rtl/log5x5_edge_filter.sv =====
// Top level of the streaming 5x5 Laplacian-of-Gaussian edge filter.
//
// Streaming 5x5 Laplacian-of-Gaussian edge filter for 8-bit grayscale
// frames in raster order. One pixel request is taken per clock while
// pix_stall is low, and at most one filtered pixel leaves per clock. While
// a finished pixel waits on res_stall, one more request is taken into
// stage one and pix_stall then holds the input until the result leaves.
// A result belongs to the pixel 2*W+2 requests earlier, so after the last
// pixel of a frame send 2*W+2 requests with drain set to flush the final
// rows (a drain that still falls inside the frame counts as a black
// pixel). Pixels within two of any edge are copied unchanged;
// res.out_last marks the W*H-th result, after which the counters restart
// for the next frame. A request passes from stage one into the result
// register: stage one holds the request while its column is read from
// the store, then the window shift, kernel adder tree and clamp feed the
// result register. After reset pix_stall stays high while the column
// store is swept to zero and while the setup sequencer derives its
// position state. After every register write pix_stall stays high while
// the bit-serial divider re-derives the output row and column from the
// result count. Write registers only when no request is in flight. Widths
// above MAX_WIDTH act as MAX_WIDTH; zero width or height acts as one.
module log5x5_edge_filter #(
  parameter int MAX_WIDTH = log5_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  output logic                        pix_stall,
  input  log5_pkg::in_item_t          pix,
  output logic                        res_valid,
  input  logic                        res_stall,
  output log5_pkg::out_item_t         res,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  log5_pkg::reg_index_t        cfg_index,
  input  logic [log5_pkg::CFG_W-1:0]  cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic               accept;
  logic               ctrl_busy;
  logic               store_busy;
  logic [COL_W-1:0]   col;
  log5_pkg::tag_t     tag;

  // Stage one: request held while its column is read from the store.
  logic               s1_valid;
  log5_pkg::pixel_t   s1_px;
  logic [COL_W-1:0]   s1_col;
  log5_pkg::tag_t     s1_tag;
  logic               s1_adv;
  logic               free;

  log5_pkg::column_t  rd_column;
  log5_pkg::column_t  wr_column;

  // The register port never pushes back.
  assign cfg_ready = 1'b1;

  // Stall while the store clears, while setup runs, or while stage one
  // cannot move into the result register.
  assign s1_adv    = s1_valid && free;
  assign pix_stall = store_busy || ctrl_busy || (s1_valid && !free);
  assign accept    = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Drain requests enter the window as black pixels.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px  <= pix.drain ? '0 : pix.pixel;
      s1_col <= col;
      s1_tag <= tag;
    end
  end

  log5_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .busy      (ctrl_busy),
    .col       (col),
    .tag       (tag)
  );

  log5_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col),
    .wr_en   (s1_adv),
    .wr_addr (s1_col),
    .wr_data (wr_column),
    .rd_data (rd_column),
    .busy    (store_busy)
  );

  log5_window u_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (s1_adv),
    .px        (s1_px),
    .tag       (s1_tag),
    .col_in    (rd_column),
    .col_out   (wr_column),
    .free      (free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== sim/tb_log5x5_edge_filter.sv =====
// Self-checking testbench of the streaming 5x5 LoG edge filter.
`timescale 1ns / 1ps

module tb_log5x5_edge_filter;

  localparam int MAX_W   = log5_pkg::MAX_WIDTH_DEF;
  // Cycles to hold after the last expected pixel before a register write:
  // a request that yields nothing may still sit in the two-stage pipe.
  localparam int SETTLE  = 8;
  // Quiet cycles after the final pixel, to catch any stray output.
  localparam int TAIL    = 64;
  // Cycle limit for the whole run, well above what a correct run needs.
  localparam int LIMIT   = 200_000;
  localparam int RAND_REQS = 310;

  // A queued request, with a flag that holds it back until every
  // outstanding pixel has left the block.
  typedef struct packed {
    logic               hold;
    log5_pkg::in_item_t item;
  } px_req_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 pix_valid = 1'b0;
  logic                 pix_stall;
  log5_pkg::in_item_t   pix = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  log5_pkg::out_item_t  res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  log5_pkg::reg_index_t cfg_index = log5_pkg::REG_IMAGE_WIDTH;
  logic [log5_pkg::CFG_W-1:0] cfg_data = '0;

  // Stimulus and expected output.
  px_req_t              pixel_q[$];
  log5_pkg::out_item_t  filtered_q[$];

  // Shadow of the filter: line stores, window, counters and registers.
  log5_pkg::pixel_t     line_mem [0:log5_pkg::LINES-1][0:MAX_W-1];
  log5_pkg::pixel_t     nbhd [0:log5_pkg::WIN-1][0:log5_pkg::WIN-1];
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;
  int unsigned emit_cnt = 0;
  logic [log5_pkg::CFG_W-1:0] width_sh = log5_pkg::CFG_W'(log5_pkg::WIDTH_RESET);
  logic [log5_pkg::CFG_W-1:0] height_sh = log5_pkg::CFG_W'(log5_pkg::HEIGHT_RESET);

  // Run bookkeeping.
  bit          quiet = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          fail_cnt = 0;
  int          req_cnt = 0;
  int          checked_cnt = 0;
  int          frame_cnt = 0;
  int          write_cnt = 0;
  int unsigned cycle_cnt = 0;
  log5_pkg::out_item_t want;

  log5x5_edge_filter u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Give up well past the slowest legal run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT) begin
      $display("tb_log5x5_edge_filter failed");
      $finish;
    end
  end

  // Effective sizes: zero acts as one, width clips to the line store.
  function automatic int unsigned eff_width();
    if (width_sh == 0) return 1;
    if (width_sh > MAX_W) return MAX_W;
    return width_sh;
  endfunction

  function automatic int unsigned eff_height();
    return (height_sh == 0) ? 1 : height_sh;
  endfunction

  // Weighted 5x5 sum of the current window, clamped to a pixel.
  function automatic log5_pkg::pixel_t log_sum_clamp();
    int g;
    g = 2 * (int'(nbhd[2][1]) + int'(nbhd[2][3]) + int'(nbhd[1][2]) + int'(nbhd[3][2]))
      + int'(nbhd[2][0]) + int'(nbhd[2][4]) + int'(nbhd[0][2]) + int'(nbhd[4][2])
      + int'(nbhd[1][1]) + int'(nbhd[1][3]) + int'(nbhd[3][1]) + int'(nbhd[3][3])
      - log5_pkg::CENTRE_WEIGHT * int'(nbhd[2][2]);
    if (g < 0) return '0;
    if (g > log5_pkg::PIX_MAX) return log5_pkg::pixel_t'(log5_pkg::PIX_MAX);
    return log5_pkg::pixel_t'(g);
  endfunction

  // Shift one accepted request into the shadow and queue the pixel it
  // releases, if any.
  task automatic shift_in_pixel(input log5_pkg::in_item_t it);
    int unsigned         w, h, col, pos, total, kr, kc;
    log5_pkg::pixel_t    px;
    bit                  inner, last;
    log5_pkg::out_item_t r;
    w     = eff_width();
    h     = eff_height();
    px    = it.drain ? log5_pkg::pixel_t'(0) : it.pixel;
    col   = col_cnt % MAX_W;
    pos   = row_cnt * w + col_cnt;
    total = w * h;
    for (int i = 0; i < log5_pkg::WIN; i++)
      for (int j = 0; j < log5_pkg::WIN - 1; j++)
        nbhd[i][j] = nbhd[i][j+1];
    for (int i = 0; i < log5_pkg::LINES; i++)
      nbhd[i][log5_pkg::WIN-1] = line_mem[i][col];
    nbhd[log5_pkg::WIN-1][log5_pkg::WIN-1] = px;
    for (int i = 0; i < log5_pkg::LINES - 1; i++)
      line_mem[i][col] = line_mem[i+1][col];
    line_mem[log5_pkg::LINES-1][col] = px;

    if (pos >= 2 * w + 2) begin
      kr    = emit_cnt / w;
      kc    = emit_cnt % w;
      inner = kr >= log5_pkg::BORDER && kr + log5_pkg::BORDER < h
           && kc >= log5_pkg::BORDER && kc + log5_pkg::BORDER < w;
      last  = emit_cnt + 1 >= total;
      r.out_pixel = inner ? log_sum_clamp() : nbhd[2][2];
      r.out_last  = last;
      filtered_q.push_back(r);
      if (last) begin
        // Frame done: restart all counters, keep store and window.
        col_cnt  = 0;
        row_cnt  = 0;
        emit_cnt = 0;
        return;
      end
      emit_cnt++;
    end

    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt < log5_pkg::ROW_LIMIT) row_cnt++;
    end else begin
      col_cnt++;
    end
  endtask

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: present queued requests, predict each one as it is taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_valid && !pix_stall) begin
        shift_in_pixel(pix);
        req_cnt++;
      end
      // Advance only when nothing is on offer or the offer was just taken.
      if (!pix_valid || !pix_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          pix_valid <= 1'b0;
        end else if (pixel_q.size() != 0 &&
                     (!pixel_q[0].hold || filtered_q.size() == 0)) begin
          pix       <= pixel_q[0].item;
          pix_valid <= 1'b1;
          pixel_q.pop_front();
          gap_left = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken pixel with the oldest prediction, and
  // stall the output now and then.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected pixel: out_pixel %0d, out_last %0b", res.out_pixel, res.out_last);
          fail_cnt++;
        end else begin
          want = filtered_q.pop_front();
          if (res.out_pixel !== want.out_pixel) begin
            $error("out_pixel mismatch: expected %0d, actual %0d",
                   want.out_pixel, res.out_pixel);
            fail_cnt++;
          end
          if (res.out_last !== want.out_last) begin
            $error("out_last mismatch: expected %0b, actual %0b",
                   want.out_last, res.out_last);
            fail_cnt++;
          end
          checked_cnt++;
          if (want.out_last) frame_cnt++;
        end
      end
      if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 20) stall_left = idle_len();
      if (stall_left != 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  task automatic push_req(input logic hold, input logic drain, input log5_pkg::pixel_t px);
    px_req_t q;
    q.hold       = hold;
    q.item.drain = drain;
    q.item.pixel = px;
    pixel_q.push_back(q);
  endtask

  // Wait until every request is taken and every pixel is out, then settle.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || pix_valid || filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register; keep valid high when another write follows at once.
  task automatic write_reg(input log5_pkg::reg_index_t idx,
                           input logic [log5_pkg::CFG_W-1:0] val, input bit chain);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == log5_pkg::REG_IMAGE_WIDTH) width_sh = val;
    else height_sh = val;
    write_cnt++;
    if (!chain) cfg_valid <= 1'b0;
  endtask

  // Pixel content for a frame: uniform noise, small noise around a base
  // level (hits unclamped sums), or hard black/white (hits both clamps).
  function automatic log5_pkg::pixel_t pick_pixel(input int style, input int base);
    int v;
    case (style)
      0: v = $urandom_range(0, 255);
      1: begin
        v = base + $urandom_range(0, 15) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default: v = $urandom_range(0, 1) ? 255 : 0;
    endcase
    return log5_pkg::pixel_t'(v);
  endfunction

  // Queue one frame at the current size plus its flush tail. A broken
  // frame gets a random tail, which may be too short or too long.
  task automatic queue_frame(input bit broken, output int n);
    int unsigned w, h, tail;
    int          style, base;
    w     = eff_width();
    h     = eff_height();
    style = $urandom_range(0, 2);
    base  = $urandom_range(0, 255);
    tail  = broken ? $urandom_range(0, 2 * w + 7) : 2 * w + 2;
    for (int k = 0; k < w * h; k++)
      push_req(1'b0, $urandom_range(0, 19) == 0, pick_pixel(style, base));
    for (int k = 0; k < tail; k++)
      push_req(k == 0 && $urandom_range(0, 7) == 0, $urandom_range(0, 4) != 0,
               log5_pkg::pixel_t'($urandom_range(0, 255)));
    n = w * h + tail;
  endtask

  initial begin
    int n;
    int rand_reqs;
    int which;
    for (int i = 0; i < log5_pkg::LINES; i++)
      for (int j = 0; j < MAX_W; j++)
        line_mem[i][j] = '0;
    for (int i = 0; i < log5_pkg::WIN; i++)
      for (int j = 0; j < log5_pkg::WIN; j++)
        nbhd[i][j] = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // 5x5 frame, dark centre in a white field: the one inner pixel clamps high.
    write_reg(log5_pkg::REG_IMAGE_WIDTH, log5_pkg::CFG_W'(5), 1'b1);
    write_reg(log5_pkg::REG_IMAGE_HEIGHT, log5_pkg::CFG_W'(5), 1'b0);
    for (int k = 0; k < 25; k++) push_req(1'b0, 1'b0, (k == 12) ? 8'h00 : 8'hFF);
    for (int k = 0; k < 12; k++) push_req(1'b0, 1'b1, 8'h00);
    // Same size, bright centre in black: clamps low. The first pixel is a
    // drain carrying all ones (must count as black); the flush tail holds
    // off until the output is empty and mixes in real pixels past the frame.
    push_req(1'b0, 1'b1, 8'hFF);
    for (int k = 1; k < 25; k++) push_req(1'b0, 1'b0, (k == 12) ? 8'hFF : 8'h00);
    for (int k = 0; k < 12; k++)
      push_req(k == 0, k % 3 != 0, log5_pkg::pixel_t'($urandom_range(0, 255)));
    wait_idle();

    // Zero width and height act as a single pixel frame.
    write_reg(log5_pkg::REG_IMAGE_WIDTH, '0, 1'b1);
    write_reg(log5_pkg::REG_IMAGE_HEIGHT, '0, 1'b0);
    push_req(1'b0, 1'b0, 8'hA5);
    for (int k = 0; k < 4; k++) push_req(1'b0, 1'b1, 8'h00);
    wait_idle();

    // All-ones width clips to the widest line. Part of a row goes in, then
    // a resize to 3x2 wraps the column and starts the output at once.
    write_reg(log5_pkg::REG_IMAGE_WIDTH, '1, 1'b1);
    write_reg(log5_pkg::REG_IMAGE_HEIGHT, '1, 1'b0);
    for (int k = 0; k < 12; k++)
      push_req(1'b0, 1'b0, log5_pkg::pixel_t'($urandom_range(0, 255)));
    wait_idle();
    write_reg(log5_pkg::REG_IMAGE_WIDTH, log5_pkg::CFG_W'(3), 1'b1);
    write_reg(log5_pkg::REG_IMAGE_HEIGHT, log5_pkg::CFG_W'(2), 1'b0);
    for (int k = 0; k < 12; k++)
      push_req(1'b0, $urandom_range(0, 1), log5_pkg::pixel_t'($urandom_range(0, 255)));
    wait_idle();

    // Resize mid-frame: the column wraps and the shorter frame is already
    // past its end, so the next pixel closes it.
    write_reg(log5_pkg::REG_IMAGE_WIDTH, log5_pkg::CFG_W'(8), 1'b1);
    write_reg(log5_pkg::REG_IMAGE_HEIGHT, log5_pkg::CFG_W'(8), 1'b0);
    for (int k = 0; k < 30; k++)
      push_req(1'b0, 1'b0, log5_pkg::pixel_t'($urandom_range(0, 255)));
    wait_idle();
    write_reg(log5_pkg::REG_IMAGE_WIDTH, log5_pkg::CFG_W'(4), 1'b1);
    write_reg(log5_pkg::REG_IMAGE_HEIGHT, log5_pkg::CFG_W'(1), 1'b0);
    for (int k = 0; k < 10; k++)
      push_req(1'b0, $urandom_range(0, 1), log5_pkg::pixel_t'($urandom_range(0, 255)));
    wait_idle();

    // Random small frames, some with broken tails that leave a frame open.
    rand_reqs = 0;
    while (rand_reqs < RAND_REQS) begin
      which = $urandom_range(0, 3);
      if (which == 0 || which == 1)
        write_reg(log5_pkg::REG_IMAGE_WIDTH, log5_pkg::CFG_W'($urandom_range(0, 12)),
                  which == 0);
      if (which == 0 || which == 2)
        write_reg(log5_pkg::REG_IMAGE_HEIGHT, log5_pkg::CFG_W'($urandom_range(0, 9)), 1'b0);
      quiet = ($urandom_range(0, 5) == 0);
      queue_frame($urandom_range(0, 3) == 0, n);
      rand_reqs += n;
      wait_idle();
    end

    // Drop all stalls and watch for stray output.
    quiet = 1'b1;
    wait_idle();
    repeat (TAIL) @(posedge clk);

    $display("Checked %0d filtered pixels from %0d requests, %0d frames closed, %0d writes.",
             checked_cnt, req_cnt, frame_cnt, write_cnt);
    $display("Frames from one pixel up to 12x9, a clipped widest line and mid-frame resizes.");
    if (fail_cnt == 0) begin
      $display("tb_log5x5_edge_filter passed");
    end else begin
      $display("tb_log5x5_edge_filter failed");
    end
    $finish;
  end

endmodule
